[design/gnh_pkg.sv]
`default_nettype none
package gnh_pkg;

  // Default geometry
  localparam int GRID_SIDE_DEF  = 64;
  localparam int COORD_BITS_DEF = 10;

  // Command codes carried on the input tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Configuration register indexes
  localparam logic REG_CELL_SIZE     = 1'b0;
  localparam logic REG_CELL_SIZE_INV = 1'b1;

  localparam logic [15:0] CELL_SIZE_RST = 16'd4096;
  localparam logic [16:0] CELL_INV_RST  = 17'd4096;

  // 1.0 in Q.14
  localparam logic signed [16:0] ONE_Q14 = 17'sd16384;

  // One gradient vector, Q1.14 each
  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
  } gnh_grad_t;

  // Gradient table write request
  typedef struct packed {
    logic      we;
    logic [5:0] row;
    logic [5:0] col;
    gnh_grad_t grad;
  } gnh_wr_t;

  // Offsets and weights handed from the offset stages to the blend stages
  typedef struct packed {
    logic               vld;
    logic               oor;
    logic signed [16:0] dr0;
    logic signed [16:0] dr1;
    logic signed [16:0] u;
    logic signed [16:0] dc0;
    logic signed [16:0] dc1;
    logic signed [16:0] t;
  } gnh_offs_t;

endpackage
`default_nettype wire

[design/gnh_grad_mem.sv]
`default_nettype none
module gnh_grad_mem #(
  parameter int GRID_SIDE = 64
) (
  input  logic                              clk,
  input  logic                              en,
  input  gnh_pkg::gnh_wr_t                  wr,
  input  logic [$clog2(GRID_SIDE)-1:0]      rd_ri,
  input  logic [$clog2(GRID_SIDE)-1:0]      rd_ci,
  output gnh_pkg::gnh_grad_t [3:0]          grad
);
  import gnh_pkg::*;

  localparam int IW    = $clog2(GRID_SIDE);
  localparam int HW    = $clog2((GRID_SIDE + 1) / 2);
  localparam int DEPTH = 1 << (2 * HW);

  logic       in_grid;
  logic [HW-1:0] wr_rh;
  logic [HW-1:0] wr_ch;
  logic       rp_r;
  logic       cp_r;
  gnh_grad_t  bank_q_r [4];

  // Banks are split by row and column parity so the four corners never collide
  assign in_grid = (32'(wr.row) < GRID_SIDE) && (32'(wr.col) < GRID_SIDE);
  assign wr_rh   = HW'(wr.row >> 1);
  assign wr_ch   = HW'(wr.col >> 1);

  for (genvar bk = 0; bk < 4; bk++) begin : g_bank
    localparam logic PR = 1'((bk >> 1) & 1);
    localparam logic PC = 1'(bk & 1);

    gnh_grad_t     mem [DEPTH];
    logic [IW:0]   row_sum;
    logic [IW:0]   col_sum;
    logic [HW-1:0] rd_rh;
    logic [HW-1:0] rd_ch;

    // Corner in this bank is index or index+1, whichever has this parity
    always_comb begin
      row_sum = (IW+1)'(rd_ri) + (IW+1)'(PR ^ rd_ri[0]);
      col_sum = (IW+1)'(rd_ci) + (IW+1)'(PC ^ rd_ci[0]);
      rd_rh   = HW'(row_sum[IW:1]);
      rd_ch   = HW'(col_sum[IW:1]);
    end

    always_ff @(posedge clk) begin
      if (en && wr.we && in_grid && (wr.row[0] == PR) && (wr.col[0] == PC)) begin
        mem[{wr_rh, wr_ch}] <= wr.grad;
      end
      if (en) begin
        bank_q_r[bk] <= mem[{rd_rh, rd_ch}];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rp_r <= rd_ri[0];
      cp_r <= rd_ci[0];
    end
  end

  // Reorder bank outputs into corners: index {a, b}
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      grad[k] = bank_q_r[{k[1] ^ rp_r, k[0] ^ cp_r}];
    end
  end

endmodule
`default_nettype wire

[design/gnh_offset.sv]
`default_nettype none
module gnh_offset #(
  parameter int GRID_SIDE  = 64,
  parameter int COORD_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_ev,
  input  logic                              in_ld,
  input  logic [5:0]                        grad_row,
  input  logic [5:0]                        grad_col,
  input  gnh_pkg::gnh_grad_t                grad_in,
  input  logic [COORD_BITS-1:0]             point_row,
  input  logic [COORD_BITS-1:0]             point_col,
  input  logic [15:0]                       cell_size,
  input  logic [16:0]                       cell_size_inv,
  output gnh_pkg::gnh_wr_t                  wr,
  output logic [$clog2(GRID_SIDE)-1:0]      rd_ri,
  output logic [$clog2(GRID_SIDE)-1:0]      rd_ci,
  input  gnh_pkg::gnh_grad_t [3:0]          grad_b,
  output gnh_pkg::gnh_offs_t                offs,
  output gnh_pkg::gnh_grad_t [3:0]          grad_d
);
  import gnh_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int IW  = $clog2(GRID_SIDE);
  localparam int RIW = CB + 2;
  localparam int PRW = CB + 18;
  localparam int EW  = ((IW + 18 > CB + 10) ? IW + 18 : CB + 10) + 1;
  localparam int PW  = EW + 18;
  localparam logic signed [PW:0] OFF_HI = (PW+1)'(32768);
  localparam logic signed [PW:0] OFF_LO = -OFF_HI;

  // Distance times inverse, round half up to Q.14, clamp to +-2.0
  function automatic logic signed [16:0] to_cells(input logic signed [PW:0] p);
    logic signed [PW:0] s;
    s = (p + $signed((PW+1)'(1024))) >>> 11;
    if (s > OFF_HI) begin
      to_cells = 17'sd32768;
    end else if (s < OFF_LO) begin
      to_cells = -17'sd32768;
    end else begin
      to_cells = 17'(s);
    end
  endfunction

  // Stage A: cell index from coordinate times inverse
  logic [PRW-1:0] pr_nxt;
  logic [PRW-1:0] pc_nxt;
  logic           a_ev_r;
  logic           a_ld_r;
  logic [CB-1:0]  a_row_r;
  logic [CB-1:0]  a_col_r;
  logic [RIW-1:0] a_ri_r;
  logic [RIW-1:0] a_ci_r;
  logic [5:0]     a_grow_r;
  logic [5:0]     a_gcol_r;
  gnh_grad_t      a_grad_r;

  assign pr_nxt = PRW'(point_row) * PRW'(cell_size_inv) + PRW'(32768);
  assign pc_nxt = PRW'(point_col) * PRW'(cell_size_inv) + PRW'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ev_r <= 1'b0;
      a_ld_r <= 1'b0;
    end else if (en) begin
      a_ev_r <= in_ev;
      a_ld_r <= in_ld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_row_r  <= point_row;
      a_col_r  <= point_col;
      a_ri_r   <= pr_nxt[PRW-1:16];
      a_ci_r   <= pc_nxt[PRW-1:16];
      a_grow_r <= grad_row;
      a_gcol_r <= grad_col;
      a_grad_r <= grad_in;
    end
  end

  // Loads write the table here, in order with evaluate reads
  assign wr    = '{we: a_ld_r, row: a_grow_r, col: a_gcol_r, grad: a_grad_r};
  assign rd_ri = IW'(a_ri_r);
  assign rd_ci = IW'(a_ci_r);

  // Stage B: range check and corner distances in 1/512 point units
  logic                 oor_nxt;
  logic [IW-1:0]        ri_t;
  logic [IW-1:0]        ci_t;
  logic signed [IW+1:0] kr0;
  logic signed [IW+1:0] kr1;
  logic signed [IW+1:0] kc0;
  logic signed [IW+1:0] kc1;
  logic signed [16:0]   fs;
  logic signed [CB+9:0] rs;
  logic signed [CB+9:0] cs;
  logic                 b_vld_r;
  logic                 b_oor_r;
  logic signed [EW-1:0] b_er0_r;
  logic signed [EW-1:0] b_er1_r;
  logic signed [EW-1:0] b_ec0_r;
  logic signed [EW-1:0] b_ec1_r;

  always_comb begin
    oor_nxt = (32'(a_ri_r) + 32'd1 >= GRID_SIDE) || (32'(a_ci_r) + 32'd1 >= GRID_SIDE);
    ri_t    = IW'(a_ri_r);
    ci_t    = IW'(a_ci_r);
    kr0     = $signed({1'b0, ri_t, 1'b0}) - $signed((IW+2)'(1));
    kr1     = $signed({1'b0, ri_t, 1'b0}) + $signed((IW+2)'(1));
    kc0     = $signed({1'b0, ci_t, 1'b0}) - $signed((IW+2)'(1));
    kc1     = $signed({1'b0, ci_t, 1'b0}) + $signed((IW+2)'(1));
    fs      = $signed({1'b0, cell_size});
    rs      = $signed({1'b0, a_row_r, 9'd0});
    cs      = $signed({1'b0, a_col_r, 9'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_ev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_oor_r <= oor_nxt;
      b_er0_r <= EW'(fs) * EW'(kr0) - EW'(rs);
      b_er1_r <= EW'(fs) * EW'(kr1) - EW'(rs);
      b_ec0_r <= EW'(fs) * EW'(kc0) - EW'(cs);
      b_ec1_r <= EW'(fs) * EW'(kc1) - EW'(cs);
    end
  end

  // Stage C: scale distances by the inverse
  logic signed [17:0]   invs;
  logic                 c_vld_r;
  logic                 c_oor_r;
  logic signed [PW-1:0] c_pr0_r;
  logic signed [PW-1:0] c_pr1_r;
  logic signed [PW-1:0] c_pc0_r;
  logic signed [PW-1:0] c_pc1_r;
  gnh_grad_t [3:0]      c_grad_r;

  assign invs = $signed({1'b0, cell_size_inv});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_oor_r  <= b_oor_r;
      c_pr0_r  <= PW'(b_er0_r) * PW'(invs);
      c_pr1_r  <= PW'(b_er1_r) * PW'(invs);
      c_pc0_r  <= PW'(b_ec0_r) * PW'(invs);
      c_pc1_r  <= PW'(b_ec1_r) * PW'(invs);
      c_grad_r <= grad_b;
    end
  end

  // Stage D: round and clamp offsets; u and t are the negated near offsets
  gnh_offs_t       d_offs_r;
  gnh_grad_t [3:0] d_grad_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_offs_r.oor <= c_oor_r;
      d_offs_r.dr0 <= to_cells((PW+1)'(c_pr0_r));
      d_offs_r.dr1 <= to_cells((PW+1)'(c_pr1_r));
      d_offs_r.u   <= to_cells(-((PW+1)'(c_pr0_r)));
      d_offs_r.dc0 <= to_cells((PW+1)'(c_pc0_r));
      d_offs_r.dc1 <= to_cells((PW+1)'(c_pc1_r));
      d_offs_r.t   <= to_cells(-((PW+1)'(c_pc0_r)));
      d_grad_r     <= c_grad_r;
    end
    if (!rst_n) begin
      d_offs_r.vld <= 1'b0;
    end else if (en) begin
      d_offs_r.vld <= c_vld_r;
    end
  end

  assign offs   = d_offs_r;
  assign grad_d = d_grad_r;

endmodule
`default_nettype wire

[design/gnh_blend.sv]
`default_nettype none
module gnh_blend (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  gnh_pkg::gnh_offs_t       offs,
  input  gnh_pkg::gnh_grad_t [3:0] grad,
  input  logic [16:0]              cell_size_inv,
  output logic                     out_valid,
  output logic signed [15:0]       height,
  output logic                     out_of_range
);
  import gnh_pkg::*;

  // Stage E: bilinear weights and corner dot products
  logic signed [16:0] wr [2];
  logic signed [16:0] wc [2];
  logic signed [16:0] dr [2];
  logic signed [16:0] dc [2];
  logic signed [20:0] w_nxt   [4];
  logic signed [33:0] dot_nxt [4];
  logic signed [34:0] wp;
  logic               e_vld_r;
  logic               e_oor_r;
  logic signed [20:0] e_w_r   [4];
  logic signed [33:0] e_dot_r [4];

  always_comb begin
    wr[0] = ONE_Q14 - offs.u;
    wr[1] = offs.u;
    wc[0] = ONE_Q14 - offs.t;
    wc[1] = offs.t;
    dr[0] = offs.dr0;
    dr[1] = offs.dr1;
    dc[0] = offs.dc0;
    dc[1] = offs.dc1;
    wp    = '0;
    for (int k = 0; k < 4; k++) begin
      wp         = 35'(wr[k/2]) * 35'(wc[k%2]) + 35'sd8192;
      w_nxt[k]   = 21'(wp >>> 14);
      dot_nxt[k] = 34'(dr[k/2]) * 34'(grad[k].gx) + 34'(dc[k%2]) * 34'(grad[k].gy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= offs.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_oor_r <= offs.oor;
      e_w_r   <= w_nxt;
      e_dot_r <= dot_nxt;
    end
  end

  // Stage F: weight each corner
  logic               f_vld_r;
  logic               f_oor_r;
  logic signed [54:0] f_m_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_oor_r <= e_oor_r;
      for (int k = 0; k < 4; k++) begin
        f_m_r[k] <= 55'(e_dot_r[k]) * 55'(e_w_r[k]);
      end
    end
  end

  // Stage G: sum the corners and round to Q.14
  logic signed [56:0] acc_nxt;
  logic               g_vld_r;
  logic               g_oor_r;
  logic signed [29:0] g_acc_r;

  assign acc_nxt = 57'(f_m_r[0]) + 57'(f_m_r[1]) + 57'(f_m_r[2]) + 57'(f_m_r[3])
                 + 57'sd134217728;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_oor_r <= f_oor_r;
      g_acc_r <= 30'(acc_nxt >>> 28);
    end
  end

  // Stage H: scale by the inverse
  logic               h_vld_r;
  logic               h_oor_r;
  logic signed [47:0] h_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_oor_r <= g_oor_r;
      h_p_r   <= 48'(g_acc_r) * 48'($signed({1'b0, cell_size_inv}));
    end
  end

  // Output register: round, saturate, force zero when off grid
  logic signed [48:0] hs;
  logic signed [48:0] hr;
  logic signed [15:0] height_nxt;
  logic               out_valid_r;
  logic signed [15:0] height_r;
  logic               oor_r;

  always_comb begin
    hs = 49'(h_p_r) + 49'sd32768;
    hr = hs >>> 16;
    if (h_oor_r) begin
      height_nxt = '0;
    end else if (hr > 49'sd32767) begin
      height_nxt = 16'sh7fff;
    end else if (hr < -49'sd32768) begin
      height_nxt = 16'sh8000;
    end else begin
      height_nxt = 16'(hr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      height_r <= height_nxt;
      oor_r    <= h_oor_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign height       = height_r;
  assign out_of_range = oor_r;

endmodule
`default_nettype wire

[design/gradient_noise_height_eval_top.sv]
`default_nettype none
// Gradient noise height evaluator. Load items (tuser = 0) write one gradient
// into a GRID_SIDE x GRID_SIDE table; evaluate items (tuser = 1) return one
// saturated Q2.14 height per point, with out_of_range set and height zero
// when a lattice corner falls off the grid. Loads return nothing. One item
// is taken every cycle unless the output holds an untaken result; each
// result passes through nine registered stages (index multiply, corner
// distances with the table read, inverse scaling, rounding, weights and dot
// products, corner weighting, corner sum, output scaling, output register).
// A load is visible to every evaluate item taken after it. The table is not
// cleared by reset: evaluate only points whose four corners were loaded.
// Write the two cell size registers only while the block is idle.
module gradient_noise_height_eval_top #(
  parameter int GRID_SIDE  = gnh_pkg::GRID_SIDE_DEF,
  parameter int COORD_BITS = gnh_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: grad_row[5:0], grad_col[11:6], grad_x[27:12], grad_y[43:28],
  //        point_row[53:44], point_col[63:54]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // tuser: cmd[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: height[15:0], out_of_range[16], zero fill[23:17]
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [16:0] cfg_wdata
);
  import gnh_pkg::*;

  localparam int IW = $clog2(GRID_SIDE);

  logic [15:0]        cell_size_r;
  logic [16:0]        cell_inv_r;
  logic               en;
  logic               in_acc;
  gnh_grad_t          grad_in;
  gnh_wr_t            wr;
  logic [IW-1:0]      rd_ri;
  logic [IW-1:0]      rd_ci;
  gnh_grad_t [3:0]    grad_b;
  gnh_grad_t [3:0]    grad_d;
  gnh_offs_t          offs;
  logic signed [15:0] height;
  logic               oor;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= CELL_SIZE_RST;
      cell_inv_r  <= CELL_INV_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CELL_SIZE:     cell_size_r <= cfg_wdata[15:0];
        REG_CELL_SIZE_INV: cell_inv_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the output holds an untaken transfer
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;
  assign grad_in   = '{gx: in_tdata[27:12], gy: in_tdata[43:28]};

  gnh_offset #(
    .GRID_SIDE  (GRID_SIDE),
    .COORD_BITS (COORD_BITS)
  ) u_offset (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_ev         (in_acc && (in_tuser[0] == CMD_EVAL)),
    .in_ld         (in_acc && (in_tuser[0] == CMD_LOAD)),
    .grad_row      (in_tdata[5:0]),
    .grad_col      (in_tdata[11:6]),
    .grad_in       (grad_in),
    .point_row     (COORD_BITS'(in_tdata[53:44])),
    .point_col     (COORD_BITS'(in_tdata[63:54])),
    .cell_size     (cell_size_r),
    .cell_size_inv (cell_inv_r),
    .wr            (wr),
    .rd_ri         (rd_ri),
    .rd_ci         (rd_ci),
    .grad_b        (grad_b),
    .offs          (offs),
    .grad_d        (grad_d)
  );

  gnh_grad_mem #(
    .GRID_SIDE (GRID_SIDE)
  ) u_grad_mem (
    .clk   (clk),
    .en    (en),
    .wr    (wr),
    .rd_ri (rd_ri),
    .rd_ci (rd_ci),
    .grad  (grad_b)
  );

  gnh_blend u_blend (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .offs          (offs),
    .grad          (grad_d),
    .cell_size_inv (cell_inv_r),
    .out_valid     (out_tvalid),
    .height        (height),
    .out_of_range  (oor)
  );

  assign out_tdata = {7'd0, oor, height};

endmodule
`default_nettype wire
